// ===== rtl/b2r_pkg.sv =====
// ----------------------------------------------------------------------------
// b2r_pkg: binary to radix digits, shared definitions
// Field widths, reset values and the types used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package b2r_pkg;

  localparam int unsigned VALUE_W        = 63;
  localparam int unsigned VALUE_BITS_DEF = 63;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned STORE_DEPTH    = 64;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam radix_t RADIX_RESET = radix_t'(10);
  localparam radix_t RADIX_MIN   = radix_t'(2);
  localparam radix_t RADIX_MAX   = radix_t'(36);
  localparam char_t  CHAR_ZERO   = char_t'(48);

endpackage

`default_nettype wire

// ===== rtl/b2r_if.sv =====
// ----------------------------------------------------------------------------
// b2r_if: stream interfaces
// Input word (value) and output word (digit, char, last, empty flag).
// ----------------------------------------------------------------------------
`default_nettype none

interface b2r_in_if;
  import b2r_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2r_out_if;
  import b2r_pkg::*;
  logic   valid;
  logic   ready;
  radix_t digit;
  char_t  digit_char;
  logic   last;
  logic   empty_res;

  modport source (output valid, output digit, output digit_char, output last,
                  output empty_res, input ready);
  modport sink   (input valid, input digit, input digit_char, input last,
                  input empty_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/b2r_ram.sv =====
// ----------------------------------------------------------------------------
// b2r_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module b2r_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/b2r_div.sv =====
// ----------------------------------------------------------------------------
// b2r_div: bit-serial divider
// Restoring division of the value by the radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module b2r_div #(
  parameter int unsigned VALUE_BITS = b2r_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire b2r_pkg::radix_t       divisor_i,
  output      logic                  done_o,
  output      logic [VALUE_BITS-1:0] quotient_o,
  output      b2r_pkg::radix_t       remainder_o
);

  import b2r_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_q, quo_d;
  radix_t                rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [RADIX_W:0]      trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? RADIX_W'(trial - {1'b0, divisor_i}) : RADIX_W'(trial);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/binary_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_radix_digits: binary integer to base-radix digit stream
// Repeated bit-serial division by the radix; digits stored, then sent MSB first.
// ----------------------------------------------------------------------------
// channel  dir  payload                              handshake
// in_i     in   value[62:0]                          valid/ready
// out_o    out  digit[5:0] digit_char[6:0] last      valid/ready
//               empty_res
// cfg      in   cfg_data_i[5:0] (radix)              cfg_we_i, no wait
//
// Each digit is one full division in the bit-serial divider; readout steps
// through S_RD, S_LOAD and S_SEND per digit, then waits for the output.
// A zero word goes straight to S_SEND as a single empty word.
// One word is converted at a time; in_i.ready is high only when idle.
// Reset sets the radix to 10; the digit store needs no clearing.
// A stalled output word holds until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_radix_digits #(
  parameter int unsigned VALUE_BITS = b2r_pkg::VALUE_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire b2r_pkg::radix_t  cfg_data_i,
  b2r_in_if.sink                in_i,
  b2r_out_if.source             out_o
);

  import b2r_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_LOAD = 5'b01000,
    S_SEND = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  radix_t               radix_q;
  radix_t               eff_radix;
  logic [COUNT_W-1:0]   count_q, count_d;
  radix_t               dig_q, dig_d;
  logic                 last_q, last_d;
  logic                 empty_q, empty_d;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  radix_t                div_rem;
  logic [VALUE_BITS-1:0] in_val;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_raddr;
  radix_t                ram_rdata;

  assign in_val = in_i.value[VALUE_BITS-1:0];

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dig_d        = dig_q;
    last_d       = last_q;
    empty_d      = empty_q;
    div_start    = 1'b0;
    div_dividend = div_quo;
    ram_we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          count_d = '0;
          if (in_val == '0) begin
            dig_d   = '0;
            last_d  = 1'b1;
            empty_d = 1'b1;
            state_d = S_SEND;
          end else begin
            div_start    = 1'b1;
            div_dividend = in_val;
            state_d      = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (div_quo == '0) begin
            state_d = S_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_RD: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        dig_d   = ram_rdata;
        last_d  = count_q == COUNT_W'(1);
        empty_d = 1'b0;
        count_d = count_q - 1'b1;
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_o.ready) begin
          state_d = last_q ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_raddr = ADDR_W'(count_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      radix_q <= RADIX_RESET;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        radix_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

  b2r_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (eff_radix),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  b2r_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (div_rem),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the empty word carries no character
  assign in_i.ready       = state_q == S_IDLE;
  assign out_o.valid      = state_q == S_SEND;
  assign out_o.digit      = dig_q;
  assign out_o.digit_char = empty_q ? '0 : CHAR_ZERO + {1'b0, dig_q};
  assign out_o.last       = last_q;
  assign out_o.empty_res  = empty_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_binary_to_radix_digits.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_radix_digits: self-checking bench for the radix converter
// Directed table rows, then random phases, each under its own radix setting.
// Each accepted input word gives its expected digit words (expanded, or typed
// in the row), which are compared field by field with the output stream. Both
// stream sides stall at random, and one phase runs with no stalls at all.
// ----------------------------------------------------------------------------

module tb_binary_to_radix_digits;
  import b2r_pkg::*;

  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_WORDS  = 17;
  localparam int unsigned ROWS         = 21;

  localparam value_t VALUE_MAX = '1;
  localparam value_t ALT_A     = 63'h5555_5555_5555_5555;
  localparam value_t ALT_B     = 63'h2AAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    radix_t digit;
    char_t  digit_char;
    logic   last;
    logic   empty_res;
  } digit_word_t;

  typedef struct packed {
    logic        write_radix;
    radix_t      radix;
    value_t      value;
    logic        typed;
    digit_word_t word;
  } stim_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  radix_t cfg_data_i;

  b2r_in_if  in_if ();
  b2r_out_if out_if ();

  binary_to_radix_digits u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  digit_word_t pending_digits[$];
  radix_t      radix_shadow;
  int unsigned idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned words_sent;
  int unsigned digits_seen = 0;
  int unsigned radix_writes;
  int unsigned quiet_cycles;
  stim_row_t   directed_rows [ROWS];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic radix_t base_in_use();
    if (radix_shadow < RADIX_MIN) return RADIX_MIN;
    if (radix_shadow > RADIX_MAX) return RADIX_MAX;
    return radix_shadow;
  endfunction

  task automatic queue_word(input digit_word_t w);
    pending_digits.insert(pending_digits.size(), w);
  endtask

  // Remainders come out least significant first; queue them reversed.
  task automatic expand_digits(input value_t v);
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] b;
    radix_t             rems[$];
    digit_word_t        w;
    q = v;
    b = VALUE_W'(base_in_use());
    if (q == '0) begin
      w = '{digit: '0, digit_char: '0, last: 1'b1, empty_res: 1'b1};
      queue_word(w);
      return;
    end
    while (q != '0) begin
      rems.push_front(radix_t'(q % b));
      q = q / b;
    end
    for (int k = 0; k < rems.size(); k++) begin
      w.digit      = rems[k];
      w.digit_char = CHAR_ZERO + char_t'(rems[k]);
      w.last       = (k == rems.size() - 1);
      w.empty_res  = 1'b0;
      queue_word(w);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("digit word %0d %s got %0d want %0d",
                                digits_seen, name, got, want));
  endtask

  task automatic take_digit();
    digit_word_t want;
    if (pending_digits.size() == 0) begin
      report_mismatch($sformatf("unexpected digit word %0d", out_if.digit));
      return;
    end
    want = pending_digits.pop_front();
    compare_field("digit", int'(out_if.digit), int'(want.digit));
    compare_field("digit_char", int'(out_if.digit_char), int'(want.digit_char));
    compare_field("last", int'(out_if.last), int'(want.last));
    compare_field("empty_res", int'(out_if.empty_res), int'(want.empty_res));
    digits_seen++;
  endtask

  // Called just after posedge clk_i; leaves valid high once accepted.
  task automatic send_value(input value_t v, input logic use_typed,
                            input digit_word_t typed_word);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (use_typed) queue_word(typed_word);
    else expand_digits(v);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_radix(input radix_t r);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    radix_shadow = r;
    radix_writes++;
  endtask

  function automatic value_t random_value();
    logic [63:0] raw;
    int unsigned w;
    raw = {$urandom, $urandom};
    w   = $urandom_range(1, VALUE_W);
    case ($urandom_range(15))
      0:       return '0;
      1:       return VALUE_MAX;
      default: return value_t'(raw) & ((value_t'(1) << w) - value_t'(1));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) take_digit();
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    digit_word_t none;
    radix_t      r;
    none           = '0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_data_i     <= RADIX_RESET;
    in_if.valid    <= 1'b0;
    in_if.value    <= '0;
    radix_shadow   = RADIX_RESET;
    idle_pct       = 22;
    words_sent     = 0;
    radix_writes   = 0;

    // write_radix, radix, value, typed, {digit, char, last, empty}
    directed_rows = '{
      '{1'b0, RADIX_RESET, value_t'(9), 1'b1, '{6'd9, 7'd57, 1'b1, 1'b0}},
      '{1'b0, RADIX_RESET, '0, 1'b1, '{6'd0, 7'd0, 1'b1, 1'b1}},
      '{1'b0, RADIX_RESET, value_t'(12345), 1'b0, none},
      '{1'b0, RADIX_RESET, VALUE_MAX, 1'b0, none},
      '{1'b1, radix_t'(0), value_t'(1), 1'b1, '{6'd1, 7'd49, 1'b1, 1'b0}},
      '{1'b0, radix_t'(0), VALUE_MAX, 1'b0, none},
      '{1'b1, radix_t'(1), value_t'(2), 1'b0, none},
      '{1'b0, radix_t'(1), ALT_A, 1'b0, none},
      '{1'b1, RADIX_MIN, value_t'(5), 1'b0, none},
      '{1'b0, RADIX_MIN, ALT_B, 1'b0, none},
      '{1'b1, RADIX_MAX, value_t'(35), 1'b1, '{6'd35, 7'd83, 1'b1, 1'b0}},
      '{1'b0, RADIX_MAX, VALUE_MAX, 1'b0, none},
      '{1'b0, RADIX_MAX, '0, 1'b1, '{6'd0, 7'd0, 1'b1, 1'b1}},
      '{1'b1, radix_t'(37), value_t'(35), 1'b1, '{6'd35, 7'd83, 1'b1, 1'b0}},
      '{1'b1, radix_t'(63), value_t'(36), 1'b0, none},
      '{1'b0, radix_t'(63), VALUE_MAX, 1'b0, none},
      '{1'b1, radix_t'(16), value_t'(255), 1'b0, none},
      '{1'b0, radix_t'(16), value_t'(16), 1'b0, none},
      '{1'b1, RADIX_RESET, value_t'(1), 1'b1, '{6'd1, 7'd49, 1'b1, 1'b0}},
      '{1'b0, RADIX_RESET, value_t'(10), 1'b0, none},
      '{1'b0, RADIX_RESET, value_t'(1000000007), 1'b0, none}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].write_radix) set_radix(directed_rows[i].radix);
      send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].word);
    end

    for (int p = 0; p < PHASES; p++) begin
      r = ($urandom_range(3) == 0) ? radix_t'($urandom_range(63))
                                   : radix_t'($urandom_range(2, 36));
      set_radix(r);
      idle_pct = (p == 2) ? 0 : 22;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold the sender off until the output side has caught up
        if (p == 1 && n == PHASE_WORDS / 2) wait_drained();
        send_value(random_value(), 1'b0, none);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_digits.size() != 0)
      report_mismatch($sformatf("%0d digit words never arrived", pending_digits.size()));

    $display("Converted %0d input words into %0d digit words", words_sent, digits_seen);
    $display("Radix written %0d times, saturating low and high settings included",
             radix_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/b2r_pkg.sv
rtl/b2r_if.sv
rtl/b2r_ram.sv
rtl/b2r_div.sv
rtl/binary_to_radix_digits.sv
tb/sv/tb_binary_to_radix_digits.sv
